// ===== rtl/assert_macros.svh =====
// Assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TLFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define TLFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define TLFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TLFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tlfd_pkg.sv =====
`timescale 1ns / 1ps

package tlfd_pkg;

  localparam int UUID_BYTES = 16;
  localparam int PIDX_W = $clog2(UUID_BYTES + 1);

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'(16 * 1024 * 1024);
  localparam logic [7:0]  CONTROL_CODE_RESET = 8'd0;
  localparam logic [7:0]  HEARTBEAT_CODE_RESET = 8'd1;

  localparam logic [2:0] HDR_LAST = 3'd4;

  typedef enum logic [1:0] {
    REG_MAX_PAYLOAD    = 2'd0,
    REG_CONTROL_CODE   = 2'd1,
    REG_HEARTBEAT_CODE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    FT_CONTROL   = 2'd0,
    FT_HEARTBEAT = 2'd1,
    FT_DATA      = 2'd2
  } frame_type_t;

  typedef struct packed {
    logic [31:0] max_payload;
    logic [7:0]  control_code;
    logic [7:0]  heartbeat_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0] frame_type;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_uuid;
    logic       end_of_frame;
    logic       short_data;
    logic       fatal;
  } result_t;

endpackage

// ===== rtl/type_length_frame_deframer_unit.sv =====
// An accepted byte passes from the input register into the result register.
// Throughput: one byte per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Header bytes other than the fifth produce no result.
// Reset (rst_n, synchronous): parser state and valids clear, registers reload defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module type_length_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_type,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_in_uuid,
  output logic        out_end_of_frame,
  output logic        out_short_data,
  output logic        out_fatal
);

  tlfd_pkg::cfg_t    cfg_r;
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_adv;
  logic              can_load;
  logic              has_result;
  tlfd_pkg::result_t res;
  tlfd_pkg::result_t res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload    <= tlfd_pkg::MAX_PAYLOAD_RESET;
      cfg_r.control_code   <= tlfd_pkg::CONTROL_CODE_RESET;
      cfg_r.heartbeat_code <= tlfd_pkg::HEARTBEAT_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlfd_pkg::REG_MAX_PAYLOAD:    cfg_r.max_payload    <= cfg_data;
        tlfd_pkg::REG_CONTROL_CODE:   cfg_r.control_code   <= cfg_data[7:0];
        tlfd_pkg::REG_HEARTBEAT_CODE: cfg_r.heartbeat_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid_r && can_load;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
  end

  tlfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .byte_in    (s1_byte_r),
    .cfg        (cfg_r),
    .has_result (has_result),
    .res        (res)
  );

  tlfd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv && has_result),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_frame_type   = res_q.frame_type;
  assign out_byte         = res_q.out_byte;
  assign out_byte_valid   = res_q.byte_valid;
  assign out_in_uuid      = res_q.in_uuid;
  assign out_end_of_frame = res_q.end_of_frame;
  assign out_short_data   = res_q.short_data;
  assign out_fatal        = res_q.fatal;

  `TLFD_ASSERT_NXT(a_stall_hold, clk, rst_n, s1_valid_r && !s1_adv,
                   s1_valid_r && $stable(s1_byte_r))
  `TLFD_ASSERT_IMP(a_uuid_data, clk, rst_n, out_valid && out_in_uuid,
                   out_byte_valid && out_frame_type == tlfd_pkg::FT_DATA)
  `TLFD_ASSERT_IMP(a_short_eof, clk, rst_n, out_valid && out_short_data, out_end_of_frame)

endmodule

// ===== rtl/tlfd_parser.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlfd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  input  tlfd_pkg::cfg_t       cfg,
  output logic                 has_result,
  output tlfd_pkg::result_t    res
);

  logic [2:0]                  header_count_r, header_count_nxt;
  logic [7:0]                  type_reg_r, type_reg_nxt;
  logic [31:0]                 length_shift_r, length_shift_nxt;
  logic [31:0]                 bytes_left_r, bytes_left_nxt;
  logic [tlfd_pkg::PIDX_W-1:0] payload_index_r, payload_index_nxt;
  logic                        in_payload_r, in_payload_nxt;

  tlfd_pkg::frame_type_t       ft;
  logic                        is_data;
  logic                        in_prefix;
  logic [tlfd_pkg::PIDX_W-1:0] pidx_inc;
  logic [31:0]                 len_v;

  always_comb begin
    if (type_reg_r == cfg.control_code) begin
      ft = tlfd_pkg::FT_CONTROL;
    end else if (type_reg_r == cfg.heartbeat_code) begin
      ft = tlfd_pkg::FT_HEARTBEAT;
    end else begin
      ft = tlfd_pkg::FT_DATA;
    end
  end

  assign is_data   = (ft == tlfd_pkg::FT_DATA);
  assign in_prefix = (payload_index_r < tlfd_pkg::PIDX_W'(tlfd_pkg::UUID_BYTES));
  assign pidx_inc  = in_prefix ? payload_index_r + tlfd_pkg::PIDX_W'(1) : payload_index_r;
  assign len_v     = {length_shift_r[23:0], byte_in};

  always_comb begin
    header_count_nxt  = header_count_r;
    type_reg_nxt      = type_reg_r;
    length_shift_nxt  = length_shift_r;
    bytes_left_nxt    = bytes_left_r;
    payload_index_nxt = payload_index_r;
    in_payload_nxt    = in_payload_r;
    has_result        = 1'b0;
    res               = '0;
    res.frame_type    = ft;

    if (step) begin
      if (in_payload_r) begin
        has_result       = 1'b1;
        res.out_byte     = byte_in;
        res.byte_valid   = 1'b1;
        res.in_uuid      = is_data && in_prefix;
        bytes_left_nxt   = bytes_left_r - 32'd1;
        payload_index_nxt = pidx_inc;
        if (bytes_left_r == 32'd1) begin
          res.end_of_frame  = 1'b1;
          res.short_data    = is_data &&
                              (pidx_inc < tlfd_pkg::PIDX_W'(tlfd_pkg::UUID_BYTES));
          in_payload_nxt    = 1'b0;
          payload_index_nxt = '0;
        end
      end else if (header_count_r == 3'd0) begin
        type_reg_nxt     = byte_in;
        length_shift_nxt = '0;
        header_count_nxt = 3'd1;
      end else begin
        length_shift_nxt = len_v;
        if (header_count_r < tlfd_pkg::HDR_LAST) begin
          header_count_nxt = header_count_r + 3'd1;
        end else begin
          header_count_nxt = 3'd0;
          if (len_v > cfg.max_payload) begin
            has_result = 1'b1;
            res.fatal  = 1'b1;
          end else if (len_v == 32'd0) begin
            has_result       = 1'b1;
            res.end_of_frame = 1'b1;
            res.short_data   = is_data;
          end else begin
            bytes_left_nxt    = len_v;
            payload_index_nxt = '0;
            in_payload_nxt    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r  <= '0;
      type_reg_r      <= '0;
      length_shift_r  <= '0;
      bytes_left_r    <= '0;
      payload_index_r <= '0;
      in_payload_r    <= 1'b0;
    end else begin
      header_count_r  <= header_count_nxt;
      type_reg_r      <= type_reg_nxt;
      length_shift_r  <= length_shift_nxt;
      bytes_left_r    <= bytes_left_nxt;
      payload_index_r <= payload_index_nxt;
      in_payload_r    <= in_payload_nxt;
    end
  end

  `TLFD_ASSERT_IMP(a_payload_no_hdr, clk, rst_n, in_payload_r, header_count_r == 3'd0)
  `TLFD_ASSERT_IMP(a_hdr_range, clk, rst_n, 1'b1, header_count_r <= tlfd_pkg::HDR_LAST)
  `TLFD_ASSERT_IMP(a_pidx_sat, clk, rst_n, 1'b1,
                   payload_index_r <= tlfd_pkg::PIDX_W'(tlfd_pkg::UUID_BYTES))
  `TLFD_ASSERT_IMP(a_left_nonzero, clk, rst_n, in_payload_r, bytes_left_r != 32'd0)
  `TLFD_ASSERT_IMP(a_payload_result, clk, rst_n, step && in_payload_r,
                   has_result && res.byte_valid)

endmodule

// ===== rtl/tlfd_out_reg.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlfd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tlfd_pkg::result_t res_in,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output tlfd_pkg::result_t res_out
);

  logic              valid_r, valid_nxt;
  tlfd_pkg::result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = data_r;

  `TLFD_ASSERT_IMP(a_load_room, clk, rst_n, load, can_load)
  `TLFD_ASSERT_NXT(a_load_shows, clk, rst_n, load, valid_r && data_r == $past(res_in))
  `TLFD_ASSERT_IMP(a_fatal_clean, clk, rst_n, valid_r && data_r.fatal,
                   !data_r.byte_valid && !data_r.end_of_frame)

endmodule

// ===== tb/sv/type_length_frame_deframer_unit_tb.sv =====
`timescale 1ns / 1ps

module type_length_frame_deframer_unit_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = tlfd_pkg::REG_MAX_PAYLOAD;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_frame_type;
  logic [7:0] out_byte;
  logic out_byte_valid;
  logic out_in_uuid;
  logic out_end_of_frame;
  logic out_short_data;
  logic out_fatal;

  type_length_frame_deframer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_frame_type(out_frame_type),
    .out_byte(out_byte),
    .out_byte_valid(out_byte_valid),
    .out_in_uuid(out_in_uuid),
    .out_end_of_frame(out_end_of_frame),
    .out_short_data(out_short_data),
    .out_fatal(out_fatal)
  );

  // deframer model state
  logic [31:0] cfg_max_payload;
  logic [7:0] cfg_control;
  logic [7:0] cfg_heartbeat;
  logic [2:0] hdr_count;
  logic [7:0] cur_type;
  logic [31:0] hdr_len;
  logic [31:0] remaining;
  logic [tlfd_pkg::PIDX_W-1:0] uuid_index;
  logic in_frame_payload;

  logic [7:0] tx_stream[$];
  tlfd_pkg::result_t predicted_results[$];
  int queued_bytes = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic tlfd_pkg::frame_type_t map_frame_type(input logic [7:0] code);
    if (code == cfg_control) return tlfd_pkg::FT_CONTROL;
    if (code == cfg_heartbeat) return tlfd_pkg::FT_HEARTBEAT;
    return tlfd_pkg::FT_DATA;
  endfunction

  task automatic add_expected(input tlfd_pkg::result_t r);
    predicted_results.insert(predicted_results.size(), r);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    tlfd_pkg::frame_type_t ft;
    tlfd_pkg::result_t r;
    logic is_data;
    ft = map_frame_type(cur_type);
    is_data = (ft == tlfd_pkg::FT_DATA);
    r = '0;
    r.frame_type = ft;
    if (in_frame_payload) begin
      r.out_byte = b;
      r.byte_valid = 1'b1;
      r.in_uuid = is_data && (uuid_index < tlfd_pkg::UUID_BYTES);
      if (uuid_index < tlfd_pkg::UUID_BYTES) uuid_index++;
      remaining = remaining - 32'd1;
      if (remaining == 0) begin
        r.end_of_frame = 1'b1;
        r.short_data = is_data && (uuid_index < tlfd_pkg::UUID_BYTES);
        in_frame_payload = 1'b0;
        uuid_index = '0;
      end
      add_expected(r);
    end else if (hdr_count == 0) begin
      cur_type = b;
      hdr_len = '0;
      hdr_count = 3'd1;
    end else begin
      hdr_len = {hdr_len[23:0], b};
      if (hdr_count < tlfd_pkg::HDR_LAST) begin
        hdr_count++;
      end else begin
        hdr_count = '0;
        if (hdr_len > cfg_max_payload) begin
          r.fatal = 1'b1;
          add_expected(r);
        end else if (hdr_len == 0) begin
          r.end_of_frame = 1'b1;
          r.short_data = is_data;
          add_expected(r);
        end else begin
          remaining = hdr_len;
          uuid_index = '0;
          in_frame_payload = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_byte);
      end
      if (!in_valid || in_ready) begin
        if (tx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte <= tx_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tlfd_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer: expected none, actual type %0d byte 0x%0h",
                   $time, out_frame_type, out_byte);
        end else begin
          want = predicted_results.pop_front();
          check_field("frame_type", want.frame_type, out_frame_type);
          check_field("out_byte", want.out_byte, out_byte);
          check_field("byte_valid", want.byte_valid, out_byte_valid);
          check_field("in_uuid", want.in_uuid, out_in_uuid);
          check_field("end_of_frame", want.end_of_frame, out_end_of_frame);
          check_field("short_data", want.short_data, out_short_data);
          check_field("fatal", want.fatal, out_fatal);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    tx_stream.insert(tx_stream.size(), b);
    queued_bytes++;
  endtask

  // header plus payload; payload only when the length is accepted
  task automatic queue_frame(input logic [7:0] code, input logic [31:0] len);
    push_byte(code);
    for (int i = 3; i >= 0; i--) push_byte(len[8*i +: 8]);
    if (len != 0 && len <= cfg_max_payload) begin
      repeat (len) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (tx_stream.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      tlfd_pkg::REG_MAX_PAYLOAD: cfg_max_payload = value;
      tlfd_pkg::REG_CONTROL_CODE: cfg_control = value[7:0];
      tlfd_pkg::REG_HEARTBEAT_CODE: cfg_heartbeat = value[7:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] max_len, input logic [7:0] ctrl,
                           input logic [7:0] hb);
    write_reg(tlfd_pkg::REG_MAX_PAYLOAD, max_len);
    write_reg(tlfd_pkg::REG_CONTROL_CODE, {24'($urandom), ctrl});
    write_reg(tlfd_pkg::REG_HEARTBEAT_CODE, {24'($urandom), hb});
    end_writes();
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // noise is only used while max_payload is small, so stray lengths stay short
  task automatic random_frames(input int target, input bit with_noise);
    int start;
    int r;
    logic [7:0] code;
    logic [31:0] len;
    start = queued_bytes;
    while (queued_bytes - start < target) begin
      if (with_noise && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 2))
          0: code = cfg_control;
          1: code = cfg_heartbeat;
          default: code = 8'($urandom_range(0, 255));
        endcase
        r = $urandom_range(0, 99);
        if (r < 10) begin
          len = '0;
        end else if (r < 25 && cfg_max_payload != 32'hFFFF_FFFF) begin
          if (r < 17) begin
            len = cfg_max_payload + 32'd1;
          end else begin
            len = $urandom;
            if (len <= cfg_max_payload) len = cfg_max_payload + 32'd1;
          end
        end else begin
          len = $urandom_range(1, 40);
          if (len > cfg_max_payload) begin
            len = (cfg_max_payload == 0) ? 32'd0 : 32'($urandom_range(1, cfg_max_payload));
          end
        end
        queue_frame(code, len);
      end
    end
    if (with_noise) begin
      // realign the parser to a frame boundary
      wait_idle();
      if (in_frame_payload) begin
        repeat (remaining) push_byte(8'($urandom_range(0, 255)));
      end else if (hdr_count != 0) begin
        repeat (5 - hdr_count) push_byte(8'hFF);
      end
    end
  endtask

  initial begin
    cfg_max_payload = tlfd_pkg::MAX_PAYLOAD_RESET;
    cfg_control = tlfd_pkg::CONTROL_CODE_RESET;
    cfg_heartbeat = tlfd_pkg::HEARTBEAT_CODE_RESET;
    hdr_count = '0;
    cur_type = '0;
    hdr_len = '0;
    remaining = '0;
    uuid_index = '0;
    in_frame_payload = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames at reset settings
    set_idle(0, 0);
    queue_frame(tlfd_pkg::CONTROL_CODE_RESET, 32'd0);
    queue_frame(tlfd_pkg::HEARTBEAT_CODE_RESET, 32'd0);
    queue_frame(8'hFF, 32'd0);
    queue_frame(8'h02, 32'd1);
    queue_frame(8'h80, tlfd_pkg::UUID_BYTES);
    queue_frame(8'h55, tlfd_pkg::UUID_BYTES + 1);
    queue_frame(tlfd_pkg::CONTROL_CODE_RESET, 32'd3);
    queue_frame(tlfd_pkg::HEARTBEAT_CODE_RESET, 32'd2);
    queue_frame(8'hFF, tlfd_pkg::MAX_PAYLOAD_RESET + 32'd1);
    queue_frame(tlfd_pkg::CONTROL_CODE_RESET, 32'hFFFF_FFFF);
    queue_frame(8'h7F, 32'h01AA_5501);
    wait_idle();

    set_idle(55, 0);
    random_frames(40, 1'b0);
    wait_idle();
    random_frames(40, 1'b0);
    wait_idle();

    // equal codes, zero maximum
    configure(32'd0, 8'hFF, 8'hFF);
    set_idle(0, 55);
    random_frames(70, 1'b1);
    wait_idle();

    configure(32'd40, 8'h80, 8'h7F);
    set_idle(32, 32);
    random_frames(110, 1'b1);
    wait_idle();

    configure(32'hFFFF_FFFF, 8'h00, 8'hFF);
    set_idle(0, 0);
    random_frames(80, 1'b0);
    wait_idle();

    // code rewritten in the middle of a payload
    configure(32'd16, 8'h03, 8'h04);
    set_idle(55, 0);
    queue_frame(8'h03, 32'd0);
    push_byte(8'h03);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h0A);
    repeat (4) push_byte(8'($urandom_range(0, 255)));
    wait_idle();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    write_reg(tlfd_pkg::REG_CONTROL_CODE, 32'h0000_0009);
    end_writes();
    repeat (6) push_byte(8'($urandom_range(0, 255)));
    random_frames(70, 1'b1);
    wait_idle();

    configure(tlfd_pkg::MAX_PAYLOAD_RESET, tlfd_pkg::CONTROL_CODE_RESET,
              tlfd_pkg::HEARTBEAT_CODE_RESET);
    set_idle(0, 55);
    random_frames(40, 1'b0);
    set_idle(32, 32);
    random_frames(40, 1'b0);
    wait_idle();

    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
